// ===== rtl/bgc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the backlight gamma curve.
// Used by bgc_ctrl, bgc_datapath and backlight_gamma_curve; depends on nothing.
package bgc_pkg;

   // Exponent ceiling (gamma times one hundred) and the linear pass-through code
   localparam logic [9:0]  GAMMA_LIMIT     = 10'd1000;
   localparam logic [9:0]  GAMMA_LINEAR    = 10'd100;
   localparam logic [7:0]  LEVEL_FULL      = 8'd255;
   localparam logic [6:0]  HUNDRED         = 7'd100;
   // floor(g / 100) == (g * 41) >> 12 for g up to 1000
   localparam logic [5:0]  WHOLE_RECIP     = 6'd41;
   // floor(x / 100) == (x * 5243) >> 19 for x below 2^15
   localparam logic [12:0] HUNDREDTH_RECIP = 13'd5243;
   localparam logic [2:0]  DIV_STEPS_LAST  = 3'd7;

   typedef enum logic [0:0] {
      CSR_GAMMA     = 1'b0,
      CSR_MAX_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ZERO,
      OP_LINEAR,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_BASE,
      OP_POW,
      OP_FRAC_N,
      OP_FRAC_MUL,
      OP_FRAC_SUB,
      OP_RESCALE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_BASE,
      ST_CURVE,
      ST_FRAC_N,
      ST_FRAC_MUL,
      ST_FRAC_SUB,
      ST_RESCALE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic max_zero;
      logic linear;
      logic base_edge;
      logic whole_zero;
      logic frac_zero;
   } status_type;

   // Divide by 255 without a divider; exact for x up to 65279 (quotient fits 8 bits)
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] s;
      s = x + {8'd0, x[15:8]} + 16'd1;
      return s[15:8];
   endfunction

   // Divide by 100 through a reciprocal multiply; exact for x below 25600 (quotient fits 8 bits)
   function automatic logic [7:0] div100(input logic [14:0] x);
      logic [27:0] p;
      p = {13'd0, x} * {15'd0, HUNDREDTH_RECIP};
      return p[26:19];
   endfunction

endpackage

// ===== rtl/backlight_gamma_curve.sv =====
// The result strobe follows decode directly for linear gamma or zero max level.
// Otherwise it follows the restoring divider, the shared multiply-rescale loop (one
// pass per whole exponent unit, skipped for a base of 0 or 255), any fractional
// steps and a rescale. One transaction at a time; busy holds until the strobe ends.
// Reset (synchronous) returns to idle with gamma 100 and max level 255.
// The receiver cannot stall: each result is shown for exactly one cycle.
module backlight_gamma_curve
   import bgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_requested_level,
   output logic        rsp_valid,
   output logic [7:0]  rsp_drive_level,
   output logic [7:0]  rsp_clamped_level,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_write_data
);

   op_type     op;
   status_type status;

   bgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .op        (op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bgc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index_type'(csr_index)),
      .csr_write_data      (csr_write_data),
      .req_requested_level (req_requested_level),
      .op                  (op),
      .status              (status),
      .rsp_drive_level     (rsp_drive_level),
      .rsp_clamped_level   (rsp_clamped_level)
   );

   // A result strobe only belongs to a transaction in flight
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   // An accepted transaction holds busy and gives no result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
                    (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction not held");

   // Each result is strobed for one cycle and ends the transaction
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/bgc_ctrl.sv =====
// Sequencing state machine for the backlight gamma curve.
// Depends on bgc_pkg; drives datapath ops and reads datapath status.
module bgc_ctrl
   import bgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output op_type     op,
   output logic       busy,
   output logic       rsp_valid
);

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   // State and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath op
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op        = OP_NONE;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op       = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.max_zero) begin
               op       = OP_ZERO;
               state_in = ST_RESPOND;
            end else if (status.linear) begin
               op       = OP_LINEAR;
               state_in = ST_RESPOND;
            end else begin
               op       = OP_DIV_INIT;
               cnt_in   = DIV_STEPS_LAST;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle
            op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_BASE;
            end else begin
               cnt_in = cnt_ff - 3'd1;
            end
         end
         ST_BASE: begin
            op       = OP_BASE;
            state_in = status.base_edge ? ST_RESCALE : ST_CURVE;
         end
         ST_CURVE: begin
            // one multiply-rescale per whole exponent unit
            if (status.whole_zero) begin
               state_in = status.frac_zero ? ST_RESCALE : ST_FRAC_N;
            end else begin
               op = OP_POW;
            end
         end
         ST_FRAC_N: begin
            op       = OP_FRAC_N;
            state_in = ST_FRAC_MUL;
         end
         ST_FRAC_MUL: begin
            op       = OP_FRAC_MUL;
            state_in = ST_FRAC_SUB;
         end
         ST_FRAC_SUB: begin
            op       = OP_FRAC_SUB;
            state_in = ST_RESCALE;
         end
         ST_RESCALE: begin
            op       = OP_RESCALE;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/bgc_datapath.sv =====
// Datapath of the backlight gamma curve: config registers, divider, power curve.
// Depends on bgc_pkg; executes one op per cycle from bgc_ctrl.
module bgc_datapath
   import bgc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  logic [9:0]    csr_write_data,
   input  logic [15:0]   req_requested_level,
   input  op_type        op,
   output status_type    status,
   output logic [7:0]    rsp_drive_level,
   output logic [7:0]    rsp_clamped_level
);

   logic [9:0]  gamma_ff;
   logic [7:0]  max_ff;
   logic [7:0]  clamped_ff;
   logic        linear_ff;
   logic [3:0]  whole_ff;
   logic [6:0]  frac_ff;
   logic [7:0]  rem_ff;
   logic [7:0]  dvd_ff;
   logic [7:0]  base_ff;
   logic [7:0]  r_ff;
   logic [7:0]  n_ff;
   logic [14:0] prod_ff;
   logic [7:0]  hw_ff;

   logic [9:0]  g_lim;
   logic [15:0] whole_prod;
   logic [3:0]  whole_load;
   logic [9:0]  frac_wide;
   logic [7:0]  clamped_load;
   logic [15:0] scaled_dvd;
   logic [8:0]  trial;
   logic        trial_ge;
   logic [15:0] r_times_base;
   logic [15:0] r_times_max;
   logic [7:0]  r_less_n;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_LINEAR;
         max_ff   <= LEVEL_FULL;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAMMA:     gamma_ff <= csr_write_data;
            CSR_MAX_LEVEL: max_ff   <= csr_write_data[7:0];
            default:       ;
         endcase
      end
   end

   // Split limited gamma into whole and hundredths, clamp the request
   always_comb begin
      g_lim        = (gamma_ff > GAMMA_LIMIT) ? GAMMA_LIMIT : gamma_ff;
      whole_prod   = {6'd0, g_lim} * {10'd0, WHOLE_RECIP};
      whole_load   = whole_prod[15:12];
      frac_wide    = g_lim - ({6'd0, whole_load} * {3'd0, HUNDRED});
      clamped_load = (req_requested_level > {8'd0, max_ff}) ?
                     max_ff : req_requested_level[7:0];
   end

   // Shared arithmetic
   always_comb begin
      scaled_dvd   = {clamped_ff, 8'd0} - {8'd0, clamped_ff};
      trial        = {rem_ff, dvd_ff[7]};
      trial_ge     = (trial >= {1'b0, max_ff});
      r_times_base = {8'd0, r_ff} * {8'd0, base_ff};
      r_times_max  = {8'd0, r_ff} * {8'd0, max_ff};
      r_less_n     = r_ff - n_ff;
   end

   // Execute the current op
   always_ff @(posedge clock) begin
      unique case (op)
         OP_NONE: ;
         OP_LOAD: begin
            clamped_ff <= clamped_load;
            linear_ff  <= (g_lim == GAMMA_LINEAR);
            whole_ff   <= whole_load;
            frac_ff    <= frac_wide[6:0];
         end
         OP_ZERO:   hw_ff <= '0;
         OP_LINEAR: hw_ff <= clamped_ff;
         OP_DIV_INIT: begin
            rem_ff <= scaled_dvd[15:8];
            dvd_ff <= scaled_dvd[7:0];
         end
         OP_DIV_STEP: begin
            // restoring step; remainder stays below max level
            rem_ff <= trial_ge ? 8'(trial - {1'b0, max_ff}) : trial[7:0];
            dvd_ff <= {dvd_ff[6:0], trial_ge};
         end
         OP_BASE: begin
            base_ff <= dvd_ff;
            r_ff    <= status.base_edge ? dvd_ff : LEVEL_FULL;
         end
         OP_POW: begin
            r_ff     <= div255(r_times_base);
            whole_ff <= whole_ff - 4'd1;
         end
         OP_FRAC_N:   n_ff    <= div255(r_times_base);
         OP_FRAC_MUL: prod_ff <= {7'd0, r_less_n} * {8'd0, frac_ff};
         OP_FRAC_SUB: r_ff    <= r_ff - div100(prod_ff);
         OP_RESCALE:  hw_ff   <= div255(r_times_max);
         default: ;
      endcase
   end

   assign status.max_zero   = (max_ff == '0);
   assign status.linear     = linear_ff;
   assign status.base_edge  = (dvd_ff == '0) || (dvd_ff == LEVEL_FULL);
   assign status.whole_zero = (whole_ff == '0);
   assign status.frac_zero  = (frac_ff == '0);

   assign rsp_drive_level   = hw_ff;
   assign rsp_clamped_level = clamped_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for backlight_gamma_curve: directed and random brightness requests
// under changing gamma and max-level settings, checked against an in-bench curve predictor.
// Depends on rtl/bgc_pkg.sv and rtl/backlight_gamma_curve.sv.
module testbench
   import bgc_pkg::*;
();

   typedef struct packed {
      logic [7:0] drive;
      logic [7:0] clamped;
   } level_pair_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_requested_level;
   logic        rsp_valid;
   logic [7:0]  rsp_drive_level;
   logic [7:0]  rsp_clamped_level;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [9:0]  csr_write_data;

   // Shadow copy of the configuration registers
   logic [9:0]  gamma_setting;
   logic [7:0]  max_setting;

   level_pair_type pending_levels[$];
   int unsigned    error_count = 0;

   backlight_gamma_curve i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_requested_level (req_requested_level),
      .rsp_valid           (rsp_valid),
      .rsp_drive_level     (rsp_drive_level),
      .rsp_clamped_level   (rsp_clamped_level),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clamp, scale to 0..255, bend by the integer power curve, scale back
   function automatic level_pair_type predict_levels(input logic [15:0] level);
      level_pair_type result;
      int unsigned    g;
      int unsigned    mx;
      int unsigned    clamped;
      int unsigned    scaled;
      int unsigned    r;
      int unsigned    n;
      int unsigned    whole;
      int unsigned    frac;
      int unsigned    drive;
      g  = gamma_setting;
      mx = max_setting;
      if (g > GAMMA_LIMIT) begin
         g = GAMMA_LIMIT;
      end
      clamped = (level < mx) ? level : mx;
      if (mx == 0) begin
         drive = 0;
      end else if (g == GAMMA_LINEAR) begin
         drive = clamped;
      end else begin
         scaled = clamped * LEVEL_FULL / mx;
         if (scaled > LEVEL_FULL) begin
            scaled = LEVEL_FULL;
         end
         if (scaled == 0 || scaled == LEVEL_FULL) begin
            r = scaled;
         end else begin
            whole = g / HUNDRED;
            frac  = g % HUNDRED;
            r     = LEVEL_FULL;
            repeat (whole) begin
               r = r * scaled / LEVEL_FULL;
            end
            // Step toward the next power; n never exceeds r, so truncation is a floor
            if (frac != 0) begin
               n = r * scaled / LEVEL_FULL;
               r = r - (r - n) * frac / HUNDRED;
            end
            if (r > LEVEL_FULL) begin
               r = LEVEL_FULL;
            end
         end
         drive = r * mx / LEVEL_FULL;
      end
      result.drive   = drive[7:0];
      result.clamped = clamped[7:0];
      return result;
   endfunction

   // Send one request (after a random gap unless no_gap) and record its expected response
   task automatic send_level(input logic [15:0] level, input bit no_gap);
      int unsigned gap;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_requested_level <= level;
      do begin
         @(posedge clock);
      end while (busy);
      pending_levels.push_back(predict_levels(level));
   endtask

   // Drop start and hold until every pending transaction has responded
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [9:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_GAMMA) begin
         gamma_setting = data;
      end else begin
         max_setting = data[7:0];
      end
   endtask

   task automatic configure(input logic [9:0] gamma, input logic [9:0] max_data);
      wait_idle();
      write_register(CSR_GAMMA, gamma);
      write_register(CSR_MAX_LEVEL, max_data);
   endtask

   // Reset values: linear pass-through with full range, clamp boundaries
   task automatic test_linear_passthrough();
      send_level(16'd0, 1'b0);
      send_level(16'd1, 1'b0);
      send_level(16'd254, 1'b1);
      send_level(16'd255, 1'b1);
      send_level(16'd256, 1'b0);
      send_level(16'hFFFF, 1'b0);
   endtask

   // Curve end points pass through, interior values bend
   task automatic test_curve_edges();
      configure(10'd250, 10'd255);
      send_level(16'd0, 1'b0);
      send_level(16'd255, 1'b1);
      send_level(16'd128, 1'b0);
      send_level(16'd1, 1'b0);
   endtask

   // Zero exponent maps every nonzero level to full scale
   task automatic test_zero_gamma();
      configure(10'd0, 10'd200);
      send_level(16'd0, 1'b0);
      send_level(16'd1, 1'b0);
      send_level(16'd200, 1'b1);
   endtask

   // Exponent above the ceiling is treated as the ceiling
   task automatic test_gamma_above_limit();
      configure(10'h3FF, 10'd255);
      send_level(16'd100, 1'b0);
      send_level(16'd254, 1'b0);
   endtask

   // Zero max level zeroes both outputs; upper data bits are ignored
   task automatic test_zero_max_level();
      configure(10'd150, 10'h300);
      send_level(16'd0, 1'b0);
      send_level(16'hFFFF, 1'b0);
   endtask

   // Smallest nonzero range at the exponent ceiling
   task automatic test_smallest_range();
      configure(10'd1000, 10'd1);
      send_level(16'd0, 1'b0);
      send_level(16'd1, 1'b0);
      send_level(16'd2, 1'b1);
   endtask

   // Random settings per phase, mostly in-range requests, some bursts without gaps
   task automatic test_random_phases();
      logic [9:0]  gamma;
      logic [7:0]  max_pick;
      logic [15:0] level;
      bit          burst;
      for (int phase = 0; phase < 13; phase++) begin
         case ($urandom_range(0, 5))
            0: gamma = 10'd0;
            1: gamma = GAMMA_LINEAR;
            2: gamma = GAMMA_LIMIT;
            3: gamma = 10'h3FF;
            default: gamma = 10'($urandom_range(0, 1023));
         endcase
         case ($urandom_range(0, 7))
            0: max_pick = 8'd0;
            1: max_pick = 8'd1;
            2: max_pick = 8'd255;
            default: max_pick = 8'($urandom_range(1, 255));
         endcase
         configure(gamma, {2'($urandom_range(0, 3)), max_pick});
         burst = ($urandom_range(0, 3) == 0);
         for (int item = 0; item < 100; item++) begin
            case ($urandom_range(0, 9))
               6, 7: level = 16'($urandom_range(0, 255));
               8: level = 16'(max_setting + $urandom_range(0, 2));
               9: level = 16'($urandom_range(0, 65535));
               default: level = 16'($urandom_range(0, max_setting));
            endcase
            send_level(level, burst);
         end
      end
   endtask

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      level_pair_type expected;
      if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            $error("rsp_valid with no transaction pending");
            error_count++;
         end else begin
            expected = pending_levels.pop_front();
            if (rsp_drive_level !== expected.drive) begin
               $error("drive_level: expected %0d, got %0d", expected.drive, rsp_drive_level);
               error_count++;
            end
            if (rsp_clamped_level !== expected.clamped) begin
               $error("clamped_level: expected %0d, got %0d",
                      expected.clamped, rsp_clamped_level);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_requested_level = 16'd0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_GAMMA;
      csr_write_data      = 10'd0;
      gamma_setting       = GAMMA_LINEAR;
      max_setting         = LEVEL_FULL;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_linear_passthrough();
      test_curve_edges();
      test_zero_gamma();
      test_gamma_above_limit();
      test_zero_max_level();
      test_smallest_range();
      test_random_phases();
      wait_idle();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the handshake hangs
   initial begin
      #(12 * 600000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
